// File: hw/rtl/gscu_pkg.sv
// Shared types and constants for the GIF sub-block code unpacker.
`timescale 1ns / 1ps
`default_nettype none

package gscu_pkg;

    localparam int CODE_W   = 12;
    localparam int STATUS_W = 3;
    localparam int BYTE_BITS = 8;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EOD       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEED_MORE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] req_bits;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } t_out;

endpackage

`default_nettype wire

// File: hw/rtl/gif_subblock_code_unpacker_top.sv
// Top level of the GIF sub-block code unpacker.
//
// The input channel carries one beat per request: either a raw image-data
// byte to push (sub-block length or payload) or a request for the next code
// of a given width. Every input beat yields exactly one output beat holding
// a code and a status.
// The result of an accepted beat is registered in the result buffer, and one
// beat can be accepted in every cycle while the buffer has room: the state
// update and the code extraction are one shift, mask and compare between
// the state registers and the result register.
// A two-entry result buffer sits on the output. When the receiver stalls,
// one further beat is still accepted; input ready drops only when both
// entries hold results, and rises again as soon as one is taken.
// Reset clears the bit buffer and all flags, empties the result buffer and
// makes the next pushed byte a sub-block length.
`timescale 1ns / 1ps
`default_nettype none

module gif_subblock_code_unpacker_top #(
    parameter int MAX_CODE_BITS = 12,
    parameter int BUFFER_BITS   = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire gscu_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output gscu_pkg::t_out      o_out_data
);
    import gscu_pkg::*;

    logic accept;
    t_out result;

    assign accept = i_in_valid && o_in_ready;

    gscu_core #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .BUFFER_BITS   (BUFFER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_data),
        .o_result (result)
    );

    gscu_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (result),
        .o_room   (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_data)
    );

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_stall_only_when_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_FULL))
        else $error("status code out of range");

    a_code_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.code == '0))
        else $error("nonzero code with error status");

endmodule

`default_nettype wire

// File: hw/rtl/gscu_core.sv
// Unpacker state and the combinational push and fetch logic.
`timescale 1ns / 1ps
`default_nettype none

module gscu_core #(
    parameter int MAX_CODE_BITS = 12,
    parameter int BUFFER_BITS   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire gscu_pkg::t_in i_beat,
    output gscu_pkg::t_out     o_result
);
    import gscu_pkg::*;

    localparam int HW = $clog2(BUFFER_BITS + 1);

    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [HW-1:0]          r_held, n_held;
    logic [7:0]             r_left, n_left;
    logic                   r_expect, n_expect;
    logic                   r_term, n_term;
    logic                   r_ended, n_ended;

    logic [HW-1:0]          size_ext;
    logic [HW-1:0]          cs;
    logic [BUFFER_BITS-1:0] mask;
    logic [BUFFER_BITS-1:0] masked;
    logic [HW:0]            held_plus_byte;
    logic                   full;

    always_comb begin
        size_ext = {{(HW-4){1'b0}}, i_beat.req_bits};
        if (size_ext == '0) begin
            cs = HW'(1);
        end else if (size_ext > HW'(MAX_CODE_BITS)) begin
            cs = HW'(MAX_CODE_BITS);
        end else begin
            cs = size_ext;
        end
        mask           = ~({BUFFER_BITS{1'b1}} << cs);
        masked         = r_buf & mask;
        held_plus_byte = {1'b0, r_held} + (HW+1)'(BYTE_BITS);
        full           = held_plus_byte > (HW+1)'(BUFFER_BITS);
    end

    always_comb begin
        n_buf    = r_buf;
        n_held   = r_held;
        n_left   = r_left;
        n_expect = r_expect;
        n_term   = r_term;
        n_ended  = r_ended;
        o_result.code   = '0;
        o_result.status = ST_OK;
        if (i_beat.action == ACT_PUSH) begin
            if (r_term) begin
                o_result.status = ST_EOD;
            end else if (r_ended) begin
                o_result.status = ST_NO_DATA;
            end else if (r_expect) begin
                if (i_beat.data_byte == 8'd0) begin
                    n_term = 1'b1;
                end else begin
                    n_left   = i_beat.data_byte;
                    n_expect = 1'b0;
                end
                if (i_beat.last_byte) begin
                    n_ended = 1'b1;
                end
            end else if (full) begin
                o_result.status = ST_FULL;
            end else begin
                n_buf  = r_buf | (BUFFER_BITS'(i_beat.data_byte) << r_held);
                n_held = r_held + HW'(BYTE_BITS);
                n_left = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    n_expect = 1'b1;
                end
                if (i_beat.last_byte) begin
                    n_ended = 1'b1;
                end
            end
        end else begin
            if (r_held < cs) begin
                if (r_term) begin
                    o_result.status = ST_EOD;
                end else if (r_ended) begin
                    o_result.status = ST_NO_DATA;
                end else begin
                    o_result.status = ST_NEED_MORE;
                end
            end else begin
                o_result.code = masked[CODE_W-1:0];
                n_buf         = r_buf >> cs;
                n_held        = r_held - cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_held   <= '0;
            r_left   <= '0;
            r_expect <= 1'b1;
            r_term   <= 1'b0;
            r_ended  <= 1'b0;
        end else if (i_accept) begin
            r_buf    <= n_buf;
            r_held   <= n_held;
            r_left   <= n_left;
            r_expect <= n_expect;
            r_term   <= n_term;
            r_ended  <= n_ended;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gscu_skid.sv
// Two-entry result buffer that keeps input acceptance going through a receiver stall.
`timescale 1ns / 1ps
`default_nettype none

module gscu_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gscu_pkg::t_out i_result,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output gscu_pkg::t_out      o_result
);
    import gscu_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic pop;

    assign pop      = r_out_valid && i_ready;
    assign o_room   = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule

`default_nettype wire

// File: test/gif_subblock_code_unpacker_top_test.sv
// Self-checking testbench for the GIF sub-block code unpacker top level.
`timescale 1ns / 1ps

module gif_subblock_code_unpacker_top_test;
    import gscu_pkg::*;

    localparam int MAX_CODE     = 12;
    localparam int BUF_BITS     = 32;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BEATS = 1300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic o_in_ready;
    t_in  in_data;
    logic o_out_valid;
    logic out_ready;
    t_out out_data;

    gif_subblock_code_unpacker_top #(
        .MAX_CODE_BITS(MAX_CODE),
        .BUFFER_BITS  (BUF_BITS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mirror of the unpacker state.
    logic [63:0] bitbuf_q;
    int unsigned bits_q;
    logic [7:0]  blk_left_q;
    bit          want_len_q;
    bit          term_q;
    bit          ended_q;

    t_out expected_results[$];
    int   fail_count;
    int   idle_cycles;
    int   stall_left;
    bit   send_gaps;
    bit   recv_stalls;

    function automatic t_out unpack_step(input t_in beat);
        t_out        res;
        int unsigned width;
        logic [63:0] mask;
        res = '0;
        res.status = ST_OK;
        if (beat.action == ACT_PUSH) begin
            if (term_q) begin
                res.status = ST_EOD;
            end else if (ended_q) begin
                res.status = ST_NO_DATA;
            end else if (want_len_q) begin
                if (beat.data_byte == 8'd0) begin
                    term_q = 1'b1;
                end else begin
                    blk_left_q = beat.data_byte;
                    want_len_q = 1'b0;
                end
                if (beat.last_byte) ended_q = 1'b1;
            end else if (bits_q + BYTE_BITS > BUF_BITS) begin
                res.status = ST_FULL;
            end else begin
                bitbuf_q = bitbuf_q | (64'(beat.data_byte) << bits_q);
                bits_q = bits_q + BYTE_BITS;
                blk_left_q = blk_left_q - 8'd1;
                if (blk_left_q == 8'd0) want_len_q = 1'b1;
                if (beat.last_byte) ended_q = 1'b1;
            end
        end else begin
            width = beat.req_bits;
            if (width < 1) width = 1;
            if (width > MAX_CODE) width = MAX_CODE;
            if (bits_q < width) begin
                if (term_q) res.status = ST_EOD;
                else if (ended_q) res.status = ST_NO_DATA;
                else res.status = ST_NEED_MORE;
            end else begin
                mask = (64'd1 << width) - 64'd1;
                res.code = CODE_W'(bitbuf_q & mask);
                bitbuf_q = bitbuf_q >> width;
                bits_q = bits_q - width;
            end
        end
        return res;
    endfunction

    always @(posedge clk) begin : result_monitor
        t_out want;
        bit   moved;
        if (!rst_n) begin
            bitbuf_q = '0;
            bits_q = 0;
            blk_left_q = '0;
            want_len_q = 1'b1;
            term_q = 1'b0;
            ended_q = 1'b0;
            expected_results.delete();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (o_out_valid && out_ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: code %0h, status %0d",
                           out_data.code, out_data.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.code !== want.code) begin
                        $error("code: expected %0h, actual %0h", want.code, out_data.code);
                        fail_count++;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                moved = 1'b1;
                expected_results.push_back(unpack_step(in_data));
            end
            if (moved) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[gif_subblock_code_unpacker_top] ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
        end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    task automatic send_beat(input t_in beat);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data = beat;
        in_valid = 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] value, input logic last);
        t_in beat;
        beat.action = ACT_PUSH;
        beat.data_byte = value;
        beat.last_byte = last;
        beat.req_bits = 4'($urandom_range(0, 15));
        send_beat(beat);
    endtask

    task automatic fetch_code(input logic [3:0] width);
        t_in beat;
        beat.action = ACT_FETCH;
        beat.data_byte = 8'($urandom_range(0, 255));
        beat.last_byte = 1'($urandom_range(0, 1));
        beat.req_bits = width;
        send_beat(beat);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_fetch_empty();
        fetch_code(4'd1);
        fetch_code(4'd0);
        fetch_code(4'd15);
    endtask

    task automatic test_single_block();
        push_byte(8'd3, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hA5, 1'b0);
        fetch_code(4'd12);
        fetch_code(4'd0);
        fetch_code(4'd15);
        fetch_code(4'd11);
        fetch_code(4'd1);
    endtask

    task automatic test_buffer_full();
        push_byte(8'd8, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h81, 1'b0);
        fetch_code(4'd13);
        push_byte(8'h81, 1'b0);
        push_byte(8'h7E, 1'b0);
        fetch_code(4'd1);
        fetch_code(4'd7);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'h3C, 1'b0);
        fetch_code(4'd12);
        fetch_code(4'd14);
    endtask

    task automatic test_random_stream();
        int i;
        int pick;
        bit blocked;
        logic [7:0] len;
        for (i = 0; i < RANDOM_BEATS; i++) begin
            send_gaps = (i < 450) || (i >= 650 && i < 1000);
            recv_stalls = send_gaps;
            if (i == 300) wait_drained();
            blocked = !want_len_q && (bits_q + BYTE_BITS > BUF_BITS);
            pick = $urandom_range(0, 99);
            if ((blocked && pick < 85) || (!blocked && bits_q >= MAX_CODE && pick < 50) ||
                (!blocked && pick < 25)) begin
                fetch_code(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 12)));
            end else if (want_len_q) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len = 8'($urandom_range(1, 10));
                else if (pick < 95) len = 8'($urandom_range(11, 64));
                else len = 8'($urandom_range(65, 255));
                push_byte(len, 1'b0);
            end else begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic test_stream_end();
        bit use_term;
        use_term = 1'($urandom_range(0, 1));
        while (!want_len_q) begin
            if (bits_q + BYTE_BITS > BUF_BITS) fetch_code(4'd12);
            else push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        while (bits_q != 0) fetch_code(4'(bits_q > MAX_CODE ? MAX_CODE : bits_q));
        if (use_term) begin
            push_byte(8'd3, 1'b0);
            repeat (3) push_byte(8'($urandom_range(0, 255)), 1'b0);
            push_byte(8'd0, 1'($urandom_range(0, 1)));
            fetch_code(4'd12);
            fetch_code(4'd12);
            fetch_code(4'd1);
        end else begin
            push_byte(8'd5, 1'b0);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            fetch_code(4'd12);
            fetch_code(4'd12);
            push_byte(8'd0, 1'b0);
        end
        repeat (30) begin
            if ($urandom_range(0, 1) == 0)
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                fetch_code(4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        stall_left = 0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        fail_count = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_fetch_empty();
        test_single_block();
        test_buffer_full();
        wait_drained();
        test_random_stream();
        test_stream_end();

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("[gif_subblock_code_unpacker_top] OK");
        end else begin
            $display("[gif_subblock_code_unpacker_top] ERROR");
        end
        $finish;
    end

endmodule
